FILE: src/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Holds the request and response beat structs and the controller command struct.
// No dependencies; every other file imports this package.
`default_nettype none

package lkvc_pkg;

   // Width of the capacity register and its value after reset.
   localparam int CSR_W = 5;
   localparam logic [CSR_W-1:0] CAPACITY_RESET = 5'd16;

   // Request type codes.
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // One request beat.
   typedef struct packed {
      logic               req_type;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_beat_type;

   // One response beat.
   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
   } rsp_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // Latch the request and the lookup results.
      logic commit;   // Apply the update and load the response.
   } ctl_cmd_type;

endpackage

`default_nettype wire

FILE: src/lkvc_ctrl.sv
// Controller for the LRU key-value cache: a two-state machine that accepts a
// request beat, then commits it once the response register is free.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lkvc_pkg::ctl_cmd_type cmd
);
   import lkvc_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;

   // The response register can take a new beat when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // A request is taken only in idle; the update waits for a free response slot.
   assign req_stall   = (state_ff != S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == S_UPDATE) && rsp_free;
   assign rsp_valid   = rsp_valid_ff;

   // State and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: src/lkvc_datapath.sv
// Datapath for the LRU key-value cache: key compare, recency ranks, value
// memory, occupancy and capacity register, and the response register.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::ctl_cmd_type         cmd,
   input  lkvc_pkg::req_beat_type        req_payload,
   input  logic                          csr_wr_en,
   input  logic [lkvc_pkg::CSR_W-1:0]    csr_wr_data,
   output lkvc_pkg::rsp_beat_type        rsp_payload
);
   import lkvc_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CSR_W) ? OCC_W : CSR_W;

   // Per-entry state.
   logic [ENTRIES-1:0]        valid_ff;
   logic signed [31:0]        key_ff       [ENTRIES];
   logic [RANK_W-1:0]         rank_ff      [ENTRIES];
   logic signed [31:0]        value_mem_ff [ENTRIES];
   logic [OCC_W-1:0]          occ_ff;
   logic [CSR_W-1:0]          cap_ff;

   // Captured request and lookup results.
   logic                      is_put_ff;
   logic signed [31:0]        key_cap_ff;
   logic signed [31:0]        wval_ff;
   logic                      hit_ff;
   logic [IDX_W-1:0]          hit_idx_ff;
   logic [RANK_W-1:0]         hit_rank_ff;
   logic                      evict_ff;
   logic [IDX_W-1:0]          victim_idx_ff;
   logic [IDX_W-1:0]          free_idx_ff;

   // Response register.
   logic                      rsp_hit_ff;
   logic                      rsp_evicted_ff;
   logic signed [31:0]        rsp_value_ff;

   // Lookup signals.
   logic [ENTRIES-1:0]        match_vec;
   logic [ENTRIES-1:0]        victim_vec;
   logic [ENTRIES-1:0]        free_vec;
   logic                      hit_in;
   logic [IDX_W-1:0]          hit_idx_in;
   logic [RANK_W-1:0]         hit_rank_in;
   logic [IDX_W-1:0]          victim_idx_in;
   logic [IDX_W-1:0]          free_idx_in;
   logic [CMP_W-1:0]          cap_ext;
   logic [CMP_W-1:0]          eff_cap;
   logic                      full_in;

   // Update controls.
   logic                      do_touch;
   logic                      do_insert;
   logic                      do_evict;

   // Effective capacity is the register saturated into 1..ENTRIES.
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      full_in = CMP_W'(occ_ff) >= eff_cap;
   end

   // Parallel key compare, victim detection and free-slot search.
   // Ranks of valid entries are always a permutation of 0..occupancy-1, so the
   // least recent entry is the one whose rank equals occupancy minus one.
   always_comb begin
      hit_in        = 1'b0;
      hit_idx_in    = '0;
      hit_rank_in   = '0;
      victim_idx_in = '0;
      free_idx_in   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i]  = valid_ff[i] && (key_ff[i] == req_payload.lookup_key);
         victim_vec[i] = valid_ff[i] &&
                         (OCC_W'(rank_ff[i]) == (occ_ff - OCC_W'(1)));
         free_vec[i]   = !valid_ff[i] || (full_in && victim_vec[i]);
         hit_in        = hit_in | match_vec[i];
         hit_rank_in   = hit_rank_in | (match_vec[i] ? rank_ff[i] : '0);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_idx_in = IDX_W'(i);
         end
         if (victim_vec[i]) begin
            victim_idx_in = IDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx_in = IDX_W'(i);
         end
      end
   end

   // Capture the request beat together with its lookup results.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_put_ff     <= (req_payload.req_type == REQ_PUT);
         key_cap_ff    <= req_payload.lookup_key;
         wval_ff       <= req_payload.write_value;
         hit_ff        <= hit_in;
         hit_idx_ff    <= hit_idx_in;
         hit_rank_ff   <= hit_rank_in;
         evict_ff      <= full_in;
         victim_idx_ff <= victim_idx_in;
         free_idx_ff   <= free_idx_in;
      end
   end

   assign do_touch  = cmd.commit && hit_ff;
   assign do_insert = cmd.commit && is_put_ff && !hit_ff;
   assign do_evict  = do_insert && evict_ff;

   // Valid bits, ranks, occupancy and the capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         cap_ff   <= CAPACITY_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         // A touch ages entries more recent than the hit; an insert ages all.
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] &&
                ((do_touch && (rank_ff[i] < hit_rank_ff)) || do_insert)) begin
               rank_ff[i] <= rank_ff[i] + RANK_W'(1);
            end
         end
         if (do_touch) begin
            rank_ff[hit_idx_ff] <= '0;
         end
         if (do_evict) begin
            valid_ff[victim_idx_ff] <= 1'b0;
         end
         if (do_insert) begin
            valid_ff[free_idx_ff] <= 1'b1;
            rank_ff[free_idx_ff]  <= '0;
            if (!evict_ff) begin
               occ_ff <= occ_ff + OCC_W'(1);
            end
         end
      end
   end

   // Key store for new entries.
   always_ff @(posedge clock) begin
      if (do_insert) begin
         key_ff[free_idx_ff] <= key_cap_ff;
      end
   end

   // Value memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.commit && is_put_ff) begin
         value_mem_ff[hit_ff ? hit_idx_ff : free_idx_ff] <= wval_ff;
      end
      if (cmd.commit) begin
         rsp_value_ff <= (!is_put_ff && hit_ff) ? value_mem_ff[hit_idx_ff] : '0;
      end
   end

   // Response flags.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= is_put_ff && !hit_ff && evict_ff;
      end
   end

   assign rsp_payload.hit        = rsp_hit_ff;
   assign rsp_payload.read_value = rsp_value_ff;
   assign rsp_payload.evicted    = rsp_evicted_ff;

endmodule

`default_nettype wire

FILE: src/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
// Instantiates lkvc_ctrl and lkvc_datapath; depends on lkvc_pkg.
//
//   Channel   Ports                          Direction  Beat
//   request   req_valid/req_stall/req_payload  in       req_type, lookup_key, write_value
//   response  rsp_valid/rsp_stall/rsp_payload  out      hit, read_value, evicted
//   config    csr_wr_en/csr_wr_data            in       capacity_limit
//
// For each request, the key compare runs in the cycle the beat is accepted, and the
// rank, valid and value-memory update runs in the S_UPDATE state once the response
// register is free; the next request is not accepted until that update has run.
// Reset clears all valid bits, ranks and occupancy and sets capacity to 16.
// A stalled response holds the update, and with it the next request, until
// the response register drains.
`default_nettype none

module lru_key_value_cache_top #(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lkvc_pkg::req_beat_type      req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lkvc_pkg::rsp_beat_type      rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [lkvc_pkg::CSR_W-1:0]  csr_wr_data
);
   import lkvc_pkg::*;

   ctl_cmd_type cmd;

   // Handshake control.
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Storage, lookup and response register.
   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: tb/lkvc_response_checker.sv
// Response checker for the LRU key-value cache: watches the request, response
// and capacity ports, keeps its own copy of the cache contents and compares beats.
// Depends on lkvc_pkg for the beat types and the capacity reset value.

module lkvc_response_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  lkvc_pkg::req_beat_type      req_payload,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  lkvc_pkg::rsp_beat_type      rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [lkvc_pkg::CSR_W-1:0]  csr_wr_data,
   output int                          error_count,
   output int                          outstanding
);
   import lkvc_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Shadow copy of the cache: one valid bit, key, value and rank per slot.
   logic               slot_valid [ENTRIES];
   logic signed [31:0] slot_key   [ENTRIES];
   logic signed [31:0] slot_value [ENTRIES];
   logic [RANK_W-1:0]  slot_rank  [ENTRIES];
   int                 fill_level;
   logic [CSR_W-1:0]   capacity_reg;

   rsp_beat_type       expected_rsp_q [$];
   rsp_beat_type       want;

   // Applies one request to the shadow cache and returns the response it must produce.
   function automatic rsp_beat_type apply_request(input req_beat_type beat);
      rsp_beat_type      result;
      int                i;
      int                found;
      int                victim;
      int                free_slot;
      int                limit;
      logic [RANK_W-1:0] aged;
      result = '0;
      found = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && slot_key[i] == beat.lookup_key && found < 0) begin
            found = i;
         end
      end
      if (found >= 0) begin
         // A hit reads or overwrites the value, then the entry becomes the most recent.
         result.hit = 1'b1;
         if (beat.req_type == REQ_GET) begin
            result.read_value = slot_value[found];
         end else begin
            slot_value[found] = beat.write_value;
         end
         aged = slot_rank[found];
         for (i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && i != found && slot_rank[i] < aged) begin
               slot_rank[i] = slot_rank[i] + 1'b1;
            end
         end
         slot_rank[found] = '0;
      end else if (beat.req_type == REQ_PUT) begin
         // The capacity register saturates into one to ENTRIES.
         if (capacity_reg == 0) begin
            limit = 1;
         end else if (int'(capacity_reg) > ENTRIES) begin
            limit = ENTRIES;
         end else begin
            limit = int'(capacity_reg);
         end
         // A full cache drops its least recent entry first, even when over capacity.
         if (fill_level >= limit) begin
            victim = -1;
            for (i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) begin
                  victim = i;
               end
            end
            if (victim >= 0) begin
               slot_valid[victim] = 1'b0;
               fill_level--;
               result.evicted = 1'b1;
            end
         end
         // The new key goes into the lowest free slot as the most recent entry.
         free_slot = -1;
         for (i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i] && free_slot < 0) begin
               free_slot = i;
            end
         end
         if (free_slot >= 0) begin
            for (i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i]) begin
                  slot_rank[i] = slot_rank[i] + 1'b1;
               end
            end
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = beat.lookup_key;
            slot_value[free_slot] = beat.write_value;
            slot_rank[free_slot]  = '0;
            fill_level++;
         end
      end
      return result;
   endfunction

   // Sample every channel at the rising edge; responses are matched before new requests.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = '0;
         end
         fill_level = 0;
         capacity_reg = CAPACITY_RESET;
         expected_rsp_q.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) begin
            capacity_reg = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with no request waiting: hit %0d, read_value %0d",
                      rsp_payload.hit, rsp_payload.read_value);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
                  error_count++;
               end
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         want.read_value, rsp_payload.read_value);
                  error_count++;
               end
               if (rsp_payload.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_payload.evicted);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(apply_request(req_payload));
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the LRU key-value cache testbench: clock, reset, request and capacity
// stimulus, response back-pressure and the verdict.
// Depends on lkvc_pkg, lru_key_value_cache_top and lkvc_response_checker.

module testbench;
   import lkvc_pkg::*;

   localparam int ENTRIES = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 200;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_beat_type       req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_beat_type       rsp_payload;
   logic               csr_wr_en;
   logic [CSR_W-1:0]   csr_wr_data;
   int                 error_count;
   int                 outstanding;

   // Idle rates in percent, and a count of requested long receiver hold-offs.
   int                 send_idle_pct;
   int                 recv_idle_pct;
   int                 hold_requests;

   // Keys drawn by the random requests; a short span keeps the hit rate up.
   logic signed [31:0] key_pool [32];
   int                 pool_span;

   lru_key_value_cache_top #(
      .ENTRIES (ENTRIES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lkvc_response_checker #(
      .ENTRIES (ENTRIES)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Response side: random stalls, or a long hold-off when one is requested.
   initial begin : recv_side
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Offers one request beat, with random idle cycles first, and returns at the
   // falling edge after it was taken. Valid stays high for a following beat.
   task automatic push_request(input req_beat_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue(input logic kind, input logic signed [31:0] key,
                        input logic signed [31:0] value);
      req_beat_type beat;
      beat.req_type    = kind;
      beat.lookup_key  = key;
      beat.write_value = value;
      push_request(beat);
   endtask

   // Stops offering and waits until every expected response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes the capacity register and sizes the key pool to match. Only while idle.
   task automatic write_capacity(input logic [CSR_W-1:0] limit);
      int usable;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      usable = (limit == 0) ? 1 : ((int'(limit) > ENTRIES) ? ENTRIES : int'(limit));
      pool_span = usable + usable / 2 + 2;
   endtask

   task automatic refill_key_pool;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 32; i++) begin
         key_pool[i] = $urandom;
      end
   endtask

   function automatic req_beat_type random_beat();
      req_beat_type beat;
      beat.req_type = $urandom_range(1) ? REQ_PUT : REQ_GET;
      if ($urandom_range(99) < 8) begin
         beat.lookup_key = $urandom;
      end else begin
         beat.lookup_key = key_pool[$urandom_range(pool_span - 1)];
      end
      beat.write_value = $urandom;
      return beat;
   endfunction

   // Stimulus: directed beats, then random phases over several capacities.
   initial begin : stimulus
      int phase;
      int n;
      int phase_caps [8];
      phase_caps = '{31, 1, 0, 7, 16, 12, 3, 16};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      pool_span     = 4;
      refill_key_pool();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extreme keys and values, a miss on the empty cache, hits and an update.
      write_capacity(5'd16);
      issue(REQ_GET, 32'h0000_0000, 32'h1234_5678);
      issue(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      issue(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      issue(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      issue(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      issue(REQ_GET, 32'h8000_0000, 32'h0000_0000);
      issue(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(REQ_PUT, 32'h7FFF_FFFF, 32'h5555_5555);
      issue(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      issue(REQ_GET, 32'h0000_0001, 32'hAAAA_AAAA);
      drain();

      // Capacity lowered below the occupancy: each new key evicts exactly one entry.
      write_capacity(5'd2);
      issue(REQ_PUT, 32'h0000_004D, 32'h0BAD_CAFE);
      issue(REQ_PUT, 32'h0000_004E, 32'h0000_0001);
      issue(REQ_GET, 32'h0000_0000, 32'h0000_0000);
      issue(REQ_GET, 32'h8000_0000, 32'h0000_0000);
      issue(REQ_GET, 32'h0000_004D, 32'h0000_0000);
      drain();

      // A capacity of zero acts as one.
      write_capacity(5'd0);
      issue(REQ_PUT, 32'h0000_0005, 32'h0000_0050);
      issue(REQ_PUT, 32'h0000_0006, 32'h0000_0060);
      issue(REQ_GET, 32'h0000_0005, 32'h0000_0000);
      issue(REQ_GET, 32'h0000_0006, 32'h0000_0000);
      issue(REQ_PUT, 32'h0000_0006, 32'hFFFF_FFFE);

      for (phase = 0; phase < 8; phase++) begin
         drain();
         if (phase == 5) begin
            phase_caps[phase] = $urandom_range(15, 2);
         end
         write_capacity(phase_caps[phase][CSR_W-1:0]);
         refill_key_pool();
         if (phase < 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 63;
         end else if (phase < 6) begin
            send_idle_pct = 63;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // With no idling, hold the receiver off so the cache backs up its input.
         if (phase == 6) begin
            hold_requests++;
         end
         for (n = 0; n < PHASE_BEATS; n++) begin
            if (n == PHASE_BEATS / 2) begin
               drain();
            end
            push_request(random_beat());
         end
      end

      drain();
      repeat (10) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: lru_key_value_cache_top.f
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache_top.sv
tb/lkvc_response_checker.sv
tb/testbench.sv
